/* sv/lodd_pkg.sv */
`timescale 1ns / 1ps

package lodd_pkg;

   localparam int unsigned OpWidth     = 1;
   localparam int unsigned ThreadWidth = 2;
   localparam int unsigned LockWidth   = 4;
   localparam int unsigned StatusWidth = 3;

   typedef enum logic [OpWidth-1:0] {
      OP_ACQUIRE = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [StatusWidth-1:0] {
      RS_OK          = 3'd0,
      RS_DEADLOCK    = 3'd1,
      RS_REL_EMPTY   = 3'd2,
      RS_REL_NOT_TOP = 3'd3,
      RS_STACK_FULL  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_EVAL,
      S_SEARCH,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       search_start;
      logic       search_step;
      logic       push;
      logic       pop;
      logic       add_edge;
      logic       set_result;
      status_type code;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic is_release;
      logic level_zero;
      logic level_full;
      logic top_match;
      logic edge_present;
      logic search_done;
      logic reached;
      logic out_free;
   } stat_type;

endpackage

/* sv/lodd_req_if.sv */
`timescale 1ns / 1ps

interface lodd_req_if;
   logic                              valid;
   logic                              ready;
   logic [lodd_pkg::OpWidth-1:0]      op;
   logic [lodd_pkg::ThreadWidth-1:0]  thread;
   logic [lodd_pkg::LockWidth-1:0]    lock_id;

   modport source (output valid, output op, output thread, output lock_id, input ready);
   modport sink   (input valid, input op, input thread, input lock_id, output ready);
endinterface

/* sv/lodd_rsp_if.sv */
`timescale 1ns / 1ps

interface lodd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lodd_pkg::StatusWidth-1:0]  status;
   logic [lodd_pkg::LockWidth-1:0]    edge_from;
   logic [lodd_pkg::LockWidth-1:0]    edge_to;

   modport source (output valid, output status, output edge_from, output edge_to, input ready);
   modport sink   (input valid, input status, input edge_from, input edge_to, output ready);
endinterface

/* sv/lodd_ctrl.sv */
`timescale 1ns / 1ps

module lodd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lodd_pkg::stat_type stat,
   output lodd_pkg::cmd_type  cmd
);

   lodd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lodd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lodd_pkg::S_IDLE: begin
            if (req_valid) state_in = lodd_pkg::S_FETCH;
         end
         lodd_pkg::S_FETCH: begin
            state_in = lodd_pkg::S_EVAL;
         end
         lodd_pkg::S_EVAL: begin
            if (!stat.is_release && !stat.level_full && !stat.level_zero &&
                !stat.top_match && !stat.edge_present) begin
               state_in = lodd_pkg::S_SEARCH;
            end else begin
               state_in = lodd_pkg::S_DONE;
            end
         end
         lodd_pkg::S_SEARCH: begin
            if (stat.search_done) state_in = lodd_pkg::S_DONE;
         end
         lodd_pkg::S_DONE: begin
            if (stat.out_free) state_in = lodd_pkg::S_IDLE;
         end
         default: state_in = lodd_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.code  = lodd_pkg::RS_OK;
      req_ready = 1'b0;
      unique case (state_ff)
         lodd_pkg::S_IDLE: begin
            req_ready   = !reset;
            cmd.capture = req_valid && !reset;
         end
         lodd_pkg::S_FETCH: begin
         end
         lodd_pkg::S_EVAL: begin
            if (!stat.is_release) begin
               if (stat.level_full) begin
                  cmd.set_result = 1'b1;
                  cmd.code       = lodd_pkg::RS_STACK_FULL;
               end else if (stat.level_zero || stat.top_match || stat.edge_present) begin
                  cmd.push       = 1'b1;
                  cmd.set_result = 1'b1;
               end else begin
                  cmd.search_start = 1'b1;
               end
            end else begin
               cmd.set_result = 1'b1;
               if (stat.level_zero) begin
                  cmd.code = lodd_pkg::RS_REL_EMPTY;
               end else if (!stat.top_match) begin
                  cmd.code = lodd_pkg::RS_REL_NOT_TOP;
               end else begin
                  cmd.pop = 1'b1;
               end
            end
         end
         lodd_pkg::S_SEARCH: begin
            cmd.search_step = 1'b1;
            if (stat.search_done) begin
               cmd.set_result = 1'b1;
               if (stat.reached) begin
                  cmd.code = lodd_pkg::RS_DEADLOCK;
               end else begin
                  cmd.add_edge = 1'b1;
                  cmd.push     = 1'b1;
               end
            end
         end
         lodd_pkg::S_DONE: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

/* sv/lodd_dp.sv */
`timescale 1ns / 1ps

module lodd_dp #(
   parameter int unsigned LOCK_COUNT   = 16,
   parameter int unsigned THREAD_COUNT = 4,
   parameter int unsigned STACK_DEPTH  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lodd_pkg::OpWidth-1:0]        req_op,
   input  logic [lodd_pkg::ThreadWidth-1:0]    req_thread,
   input  logic [lodd_pkg::LockWidth-1:0]      req_lock_id,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lodd_pkg::StatusWidth-1:0]    rsp_status,
   output logic [lodd_pkg::LockWidth-1:0]      rsp_edge_from,
   output logic [lodd_pkg::LockWidth-1:0]      rsp_edge_to,
   input  lodd_pkg::cmd_type                   cmd,
   output lodd_pkg::stat_type                  stat
);

   localparam int unsigned LkW      = $clog2(LOCK_COUNT);
   localparam int unsigned ThW      = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
   localparam int unsigned SdW      = $clog2(STACK_DEPTH);
   localparam int unsigned LvW      = $clog2(STACK_DEPTH + 1);
   localparam int unsigned RdW      = $clog2(LOCK_COUNT);
   localparam int unsigned MemDepth = THREAD_COUNT * (1 << SdW);
   localparam int unsigned ThIn     = 1 << lodd_pkg::ThreadWidth;
   localparam int unsigned LkIn     = 1 << lodd_pkg::LockWidth;

   // input folding tables
   logic [ThW-1:0] th_tbl [ThIn];
   logic [LkW-1:0] lk_tbl [LkIn];

   for (genvar g = 0; g < ThIn; g++) begin : g_th_tbl
      assign th_tbl[g] = ThW'(g % THREAD_COUNT);
   end
   for (genvar g = 0; g < LkIn; g++) begin : g_lk_tbl
      assign lk_tbl[g] = LkW'(g % LOCK_COUNT);
   end

   logic                    rel_ff;
   logic [ThW-1:0]          th_ff;
   logic [LkW-1:0]          lk_ff;
   logic [LkW-1:0]          top_ff;
   logic [LvW-1:0]          level_ff [THREAD_COUNT];
   logic [LOCK_COUNT-1:0]   graph_ff [LOCK_COUNT];
   logic [LkW-1:0]          stack_mem [MemDepth];
   logic [LOCK_COUNT-1:0]   seen_ff, frontier_ff;
   logic [LOCK_COUNT-1:0]   seen_in, frontier_in, reach_next;
   logic [RdW-1:0]          round_ff;
   lodd_pkg::status_type    code_ff;
   logic [LkW-1:0]          efrom_ff, eto_ff;
   logic                    rsp_valid_ff;
   logic [lodd_pkg::StatusWidth-1:0] rsp_status_ff;
   logic [lodd_pkg::LockWidth-1:0]   rsp_from_ff, rsp_to_ff;

   logic [LvW-1:0]          lvl;
   logic [LvW-1:0]          lvl_dec;
   logic [ThW+SdW-1:0]      rd_addr, wr_addr;

   assign lvl     = level_ff[th_ff];
   assign lvl_dec = lvl - LvW'(1);
   assign rd_addr = {th_ff, lvl_dec[SdW-1:0]};
   assign wr_addr = {th_ff, lvl[SdW-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rel_ff <= (lodd_pkg::op_type'(req_op) == lodd_pkg::OP_RELEASE);
         th_ff  <= th_tbl[req_thread];
         lk_ff  <= lk_tbl[req_lock_id];
      end
   end

   // held-lock stacks
   always_ff @(posedge clock) begin
      top_ff <= stack_mem[rd_addr];
      if (cmd.push) stack_mem[wr_addr] <= lk_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '{default: '0};
      end else if (cmd.push) begin
         level_ff[th_ff] <= lvl + LvW'(1);
      end else if (cmd.pop) begin
         level_ff[th_ff] <= lvl_dec;
      end
   end

   // lock-order graph
   always_ff @(posedge clock) begin
      if (reset) begin
         graph_ff <= '{default: '0};
      end else if (cmd.add_edge) begin
         graph_ff[top_ff][lk_ff] <= 1'b1;
      end
   end

   // frontier expansion
   always_comb begin
      reach_next = '0;
      for (int v = 0; v < LOCK_COUNT; v++) begin
         if (frontier_ff[v]) reach_next = reach_next | graph_ff[v];
      end
      seen_in     = seen_ff | reach_next;
      frontier_in = reach_next & ~seen_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.search_start) begin
         seen_ff     <= LOCK_COUNT'(1) << lk_ff;
         frontier_ff <= LOCK_COUNT'(1) << lk_ff;
         round_ff    <= '0;
      end else if (cmd.search_step) begin
         seen_ff     <= seen_in;
         frontier_ff <= frontier_in;
         round_ff    <= round_ff + RdW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         code_ff <= cmd.code;
         if (cmd.code == lodd_pkg::RS_DEADLOCK) begin
            efrom_ff <= top_ff;
            eto_ff   <= lk_ff;
         end else begin
            efrom_ff <= '0;
            eto_ff   <= '0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= code_ff;
         rsp_from_ff   <= lodd_pkg::LockWidth'(efrom_ff);
         rsp_to_ff     <= lodd_pkg::LockWidth'(eto_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_edge_from = rsp_from_ff;
   assign rsp_edge_to   = rsp_to_ff;

   assign stat.is_release   = rel_ff;
   assign stat.level_zero   = (lvl == '0);
   assign stat.level_full   = (lvl == LvW'(STACK_DEPTH));
   assign stat.top_match    = (top_ff == lk_ff);
   assign stat.edge_present = graph_ff[top_ff][lk_ff];
   assign stat.reached      = seen_in[top_ff];
   assign stat.search_done  = seen_in[top_ff] || (frontier_in == '0) ||
                              (round_ff == RdW'(LOCK_COUNT - 1));
   assign stat.out_free     = !rsp_valid_ff || rsp_ready;

endmodule

/* sv/lock_order_deadlock_detector_unit.sv */
// an accepted beat passes the FETCH, EVAL and DONE states before its result is
//   loaded; an acquire that may add a new order edge first runs frontier
//   expansion over the order graph in SEARCH, and DONE waits for a free result slot
// a new request is taken only in IDLE, after the result of the last one is loaded
// reset: synchronous; clears stack levels, the order graph and the result valid flag
`timescale 1ns / 1ps

module lock_order_deadlock_detector_unit #(
   parameter int unsigned LOCK_COUNT   = 16,
   parameter int unsigned THREAD_COUNT = 4,
   parameter int unsigned STACK_DEPTH  = 16
) (
   input  logic       clock,
   input  logic       reset,
   lodd_req_if.sink   req_ch,
   lodd_rsp_if.source rsp_ch
);

   lodd_pkg::cmd_type  cmd;
   lodd_pkg::stat_type stat;

   lodd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lodd_dp #(
      .LOCK_COUNT   (LOCK_COUNT),
      .THREAD_COUNT (THREAD_COUNT),
      .STACK_DEPTH  (STACK_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_ch.op),
      .req_thread    (req_ch.thread),
      .req_lock_id   (req_ch.lock_id),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_status    (rsp_ch.status),
      .rsp_edge_from (rsp_ch.edge_from),
      .rsp_edge_to   (rsp_ch.edge_to),
      .cmd           (cmd),
      .stat          (stat)
   );

endmodule

/* sv/lodd_checker.sv */
`timescale 1ns / 1ps

module lodd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [lodd_pkg::StatusWidth-1:0] rsp_status,
   input logic [lodd_pkg::LockWidth-1:0]   rsp_edge_from,
   input logic [lodd_pkg::LockWidth-1:0]   rsp_edge_to
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_edge_from) && $stable(rsp_edge_to))
      else $error("result beat changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == lodd_pkg::RS_OK) ||
                    (rsp_status == lodd_pkg::RS_DEADLOCK) ||
                    (rsp_status == lodd_pkg::RS_REL_EMPTY) ||
                    (rsp_status == lodd_pkg::RS_REL_NOT_TOP) ||
                    (rsp_status == lodd_pkg::RS_STACK_FULL))
      else $error("undefined status code");

   a_edge_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != lodd_pkg::RS_DEADLOCK) |->
      (rsp_edge_from == '0) && (rsp_edge_to == '0))
      else $error("edge reported without deadlock");

   a_edge_distinct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lodd_pkg::RS_DEADLOCK) |-> rsp_edge_from != rsp_edge_to)
      else $error("deadlock edge is a self loop");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind lock_order_deadlock_detector_unit lodd_checker u_lodd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_edge_from (rsp_ch.edge_from),
   .rsp_edge_to   (rsp_ch.edge_to)
);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int unsigned LockCount   = 16;
   localparam int unsigned ThreadCount = 4;
   localparam int unsigned StackDepth  = 16;
   localparam int unsigned HoldCycles  = 300;
   localparam int unsigned DrainCycles = 40;
   localparam int unsigned CycleLimit  = 600000;

   typedef struct {
      lodd_pkg::status_type           status;
      logic [lodd_pkg::LockWidth-1:0] edge_from;
      logic [lodd_pkg::LockWidth-1:0] edge_to;
   } outcome_type;

   logic clock;
   logic reset;

   lodd_req_if req_ch ();
   lodd_rsp_if rsp_ch ();

   lock_order_deadlock_detector_unit #(
      .LOCK_COUNT  (LockCount),
      .THREAD_COUNT(ThreadCount),
      .STACK_DEPTH (StackDepth)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   logic [LockCount-1:0]           lock_graph [LockCount];
   logic [lodd_pkg::LockWidth-1:0] held_locks [ThreadCount][StackDepth];
   logic [4:0]                     held_depth [ThreadCount];

   outcome_type expected_outcomes [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle   = 0;
   int unsigned recv_idle   = 0;
   int unsigned hold_asks   = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic logic lock_reaches(input logic [lodd_pkg::LockWidth-1:0] from,
                                         input logic [lodd_pkg::LockWidth-1:0] target);
      logic [LockCount-1:0] seen;
      seen = '0;
      seen[from] = 1'b1;
      repeat (LockCount) begin
         for (int v = 0; v < LockCount; v++) begin
            if (seen[v]) seen |= lock_graph[v];
         end
      end
      return seen[target];
   endfunction

   task automatic predict_outcome(input lodd_pkg::op_type op,
                                  input logic [lodd_pkg::ThreadWidth-1:0] th,
                                  input logic [lodd_pkg::LockWidth-1:0] lk);
      outcome_type                    res;
      logic [4:0]                     lvl;
      logic [lodd_pkg::LockWidth-1:0] top;
      logic                           push_ok;
      res.status    = lodd_pkg::RS_OK;
      res.edge_from = '0;
      res.edge_to   = '0;
      lvl = held_depth[th];
      if (op == lodd_pkg::OP_ACQUIRE) begin
         if (lvl >= StackDepth) begin
            res.status = lodd_pkg::RS_STACK_FULL;
         end else begin
            push_ok = 1'b1;
            if (lvl > 0) begin
               top = held_locks[th][4'(lvl - 5'd1)];
               if (top != lk && !lock_graph[top][lk]) begin
                  if (lock_reaches(lk, top)) begin
                     res.status    = lodd_pkg::RS_DEADLOCK;
                     res.edge_from = top;
                     res.edge_to   = lk;
                     push_ok       = 1'b0;
                  end else begin
                     lock_graph[top][lk] = 1'b1;
                  end
               end
            end
            if (push_ok) begin
               held_locks[th][lvl[3:0]] = lk;
               held_depth[th]           = lvl + 5'd1;
            end
         end
      end else begin
         if (lvl == 5'd0) res.status = lodd_pkg::RS_REL_EMPTY;
         else if (held_locks[th][4'(lvl - 5'd1)] != lk) res.status = lodd_pkg::RS_REL_NOT_TOP;
         else held_depth[th] = lvl - 5'd1;
      end
      expected_outcomes.push_back(res);
   endtask

   task automatic send_item(input lodd_pkg::op_type op,
                            input logic [lodd_pkg::ThreadWidth-1:0] th,
                            input logic [lodd_pkg::LockWidth-1:0] lk);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.thread  <= th;
      req_ch.lock_id <= lk;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_outcome(op, th, lk);
   endtask

   always @(posedge clock) begin
      outcome_type exp_res;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch($sformatf("unexpected beat status %0d", rsp_ch.status));
            end else begin
               exp_res = expected_outcomes.pop_front();
               if (rsp_ch.status !== exp_res.status)
                  report_mismatch($sformatf("status %0d, wanted %0d",
                                            rsp_ch.status, exp_res.status));
               if (rsp_ch.edge_from !== exp_res.edge_from)
                  report_mismatch($sformatf("edge_from %0d, wanted %0d",
                                            rsp_ch.edge_from, exp_res.edge_from));
               if (rsp_ch.edge_to !== exp_res.edge_to)
                  report_mismatch($sformatf("edge_to %0d, wanted %0d",
                                            rsp_ch.edge_to, exp_res.edge_to));
            end
         end
         if (hold_asks != hold_served) begin
            hold_served  <= hold_asks;
            hold_left    <= HoldCycles;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic test_release_errors();
      send_item(lodd_pkg::OP_RELEASE, 2'd0, 4'd0);
      send_item(lodd_pkg::OP_ACQUIRE, 2'd0, 4'd5);
      send_item(lodd_pkg::OP_RELEASE, 2'd0, 4'd6);
   endtask

   task automatic test_deadlock_report();
      send_item(lodd_pkg::OP_ACQUIRE, 2'd1, 4'd0);
      send_item(lodd_pkg::OP_ACQUIRE, 2'd1, 4'd9);
      send_item(lodd_pkg::OP_ACQUIRE, 2'd2, 4'd9);
      send_item(lodd_pkg::OP_ACQUIRE, 2'd2, 4'd0);
      send_item(lodd_pkg::OP_RELEASE, 2'd1, 4'd9);
      send_item(lodd_pkg::OP_ACQUIRE, 2'd1, 4'd9);
   endtask

   task automatic test_stack_full();
      repeat (StackDepth + 1) send_item(lodd_pkg::OP_ACQUIRE, 2'd3, 4'd15);
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned s_idle,
                                      input int unsigned r_idle);
      int unsigned                      roll;
      logic [lodd_pkg::ThreadWidth-1:0] th;
      logic [lodd_pkg::LockWidth-1:0]   lk;
      lodd_pkg::op_type                 op;
      send_idle = s_idle;
      recv_idle = r_idle;
      repeat (count) begin
         th   = lodd_pkg::ThreadWidth'($urandom_range(ThreadCount - 1));
         lk   = lodd_pkg::LockWidth'($urandom_range(LockCount - 1));
         roll = $urandom_range(99);
         if (roll < 6) op = lodd_pkg::op_type'($urandom_range(1));
         else if (held_depth[th] == 0) op = lodd_pkg::OP_ACQUIRE;
         else if (held_depth[th] == StackDepth)
            op = (roll < 15) ? lodd_pkg::OP_ACQUIRE : lodd_pkg::OP_RELEASE;
         else op = (roll < 53) ? lodd_pkg::OP_ACQUIRE : lodd_pkg::OP_RELEASE;
         if (op == lodd_pkg::OP_RELEASE && roll >= 6)
            lk = held_locks[th][4'(held_depth[th] - 5'd1)];
         send_item(op, th, lk);
      end
   endtask

   task automatic test_receiver_holdoff();
      hold_asks <= hold_asks + 1;
      test_random_traffic(40, 0, 0);
   endtask

   initial begin
      for (int i = 0; i < LockCount; i++) lock_graph[i] = '0;
      for (int t = 0; t < ThreadCount; t++) begin
         held_depth[t] = '0;
         for (int d = 0; d < StackDepth; d++) held_locks[t][d] = '0;
      end
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.op      = lodd_pkg::OP_ACQUIRE;
      req_ch.thread  = '0;
      req_ch.lock_id = '0;
      rsp_ch.ready   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_release_errors();
      test_deadlock_report();
      test_stack_full();
      test_random_traffic(600, 20, 77);
      test_random_traffic(600, 77, 20);
      test_receiver_holdoff();
      test_random_traffic(540, 0, 0);
      req_ch.valid <= 1'b0;

      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
